/* rtl/rtfd_pkg.sv */
// Package for the reload timer with free divider.
// Holds the request type, operation and register codes, and the period table.
// No dependencies.
`default_nettype none

package rtfd_pkg;

	// Operation codes; code 3 is unused and changes nothing
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// Register select codes
	localparam logic [1:0] REG_DIV    = 2'd0;
	localparam logic [1:0] REG_COUNT  = 2'd1;
	localparam logic [1:0] REG_RELOAD = 2'd2;
	localparam logic [1:0] REG_CTRL   = 2'd3;

	localparam int DIV_ACC_W   = 9;
	localparam int TIMER_ACC_W = 32;
	localparam int PERIOD_W    = 11;

	localparam logic [DIV_ACC_W:0] DIV_PERIOD = 10'd256;
	localparam int CTRL_ENABLE_BIT = 2;
	localparam logic [7:0] COUNT_TOP = 8'hff;

	typedef struct packed {
		logic [1:0] operation;
		logic [1:0] reg_select;
		logic [7:0] write_data;
	} req_t;

	// Timer period chosen by control bits 1:0
	function automatic logic [PERIOD_W-1:0] timer_period(input logic [1:0] rate);
		logic [PERIOD_W-1:0] p;
		case (rate)
			2'd0: p = 11'd1024;
			2'd1: p = 11'd16;
			2'd2: p = 11'd64;
			2'd3: p = 11'd256;
			default: p = 11'd1024;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

/* rtl/rtfd_core.sv */
// Register file and tick logic of the reload timer.
// Depends on rtfd_pkg.
`default_nettype none

module rtfd_core #(
	parameter int TICK_CYCLES = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  rtfd_pkg::req_t     req,
	output logic [7:0]         read_data,
	output logic               timer_irq
);
	import rtfd_pkg::*;

	localparam logic [DIV_ACC_W:0]     DIV_DELTA   = (DIV_ACC_W+1)'(TICK_CYCLES);
	localparam logic [TIMER_ACC_W-1:0] TIMER_DELTA = TIMER_ACC_W'(TICK_CYCLES);

	logic [7:0]             divider_q, counter_q, reload_q, control_q;
	logic [DIV_ACC_W-1:0]   div_acc_q;
	logic [TIMER_ACC_W-1:0] timer_acc_q;

	logic [DIV_ACC_W:0]     div_sum;
	logic [DIV_ACC_W-1:0]   div_acc_nxt;
	logic                   div_step;
	logic [TIMER_ACC_W-1:0] timer_sum, timer_acc_nxt;
	logic [TIMER_ACC_W-1:0] period;
	logic                   timer_step, wrap;
	logic                   is_tick, is_read, is_write;

	always_comb begin
		is_tick  = (req.operation == OP_TICK);
		is_read  = (req.operation == OP_READ);
		is_write = (req.operation == OP_WRITE);

		div_sum  = {1'b0, div_acc_q} + DIV_DELTA;
		div_step = (div_sum > DIV_PERIOD);
		div_acc_nxt = div_step ? DIV_ACC_W'(div_sum - DIV_PERIOD) : DIV_ACC_W'(div_sum);

		timer_sum  = timer_acc_q + TIMER_DELTA;
		period     = TIMER_ACC_W'(timer_period(control_q[1:0]));
		timer_step = control_q[CTRL_ENABLE_BIT] && (timer_sum > period);
		timer_acc_nxt = timer_step ? (timer_sum - period) : timer_sum;
		wrap = timer_step && (counter_q == COUNT_TOP);

		read_data = 8'd0;
		if (is_read) begin
			case (req.reg_select)
				REG_DIV:    read_data = divider_q;
				REG_COUNT:  read_data = counter_q;
				REG_RELOAD: read_data = reload_q;
				REG_CTRL:   read_data = control_q;
				default:    read_data = control_q;
			endcase
		end
		timer_irq = is_tick && wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divider_q   <= '0;
			counter_q   <= '0;
			reload_q    <= '0;
			control_q   <= '0;
			div_acc_q   <= '0;
			timer_acc_q <= '0;
		end else if (fire) begin
			if (is_tick) begin
				div_acc_q   <= div_acc_nxt;
				timer_acc_q <= timer_acc_nxt;
				if (div_step)
					divider_q <= divider_q + 8'd1;
				if (wrap)
					counter_q <= reload_q;
				else if (timer_step)
					counter_q <= counter_q + 8'd1;
			end else if (is_write) begin
				case (req.reg_select)
					REG_DIV:    divider_q <= req.write_data;
					REG_COUNT:  counter_q <= req.write_data;
					REG_RELOAD: reload_q  <= req.write_data;
					REG_CTRL:   control_q <= req.write_data;
					default:    control_q <= req.write_data;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/reload_timer_with_free_divider.sv */
// Top level of the reload timer with free divider: request and result handshakes.
// Depends on rtfd_pkg and rtfd_core.
// Each accepted request passes the request register and then the result register; rsp_valid
// rises when it enters the result register, which waits while a held result is not taken.
// Throughput: one request per cycle while results are taken; each request is applied as it
// leaves the request register, so a tick or access may follow in the very next cycle.
`default_nettype none

module reload_timer_with_free_divider #(
	parameter int TICK_CYCLES = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire logic [1:0] operation,
	input  wire logic [1:0] reg_select,
	input  wire logic [7:0] write_data,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output logic [7:0]      read_data,
	output logic            timer_irq
);
	import rtfd_pkg::*;

	// Reset: arst_n clears the timer registers, accumulators and both stage valids at once;
	// the request and result payload registers are not reset.

	// Request register
	logic       valid_s1;
	req_t       req_s1;
	// Result register
	logic       valid_s2;
	logic [7:0] read_data_s2;
	logic       irq_s2;

	logic       advance;
	logic [7:0] core_rd;
	logic       core_irq;

	// Move the held request on whenever the result register is free or draining
	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// Payload holds while the stage stalls
	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1.operation  <= operation;
			req_s1.reg_select <= reg_select;
			req_s1.write_data <= write_data;
		end
	end

	// Register state is updated exactly when the request advances
	rtfd_core #(
		.TICK_CYCLES(TICK_CYCLES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.req       (req_s1),
		.read_data (core_rd),
		.timer_irq (core_irq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_s2 <= core_rd;
			irq_s2       <= core_irq;
		end
	end

	assign rsp_valid = valid_s2;
	assign read_data = read_data_s2;
	assign timer_irq = irq_s2;

endmodule

`default_nettype wire
